### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define BXAVG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BXAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bxavg_pkg.sv
`timescale 1ns / 1ps

package bxavg_pkg;

    localparam int COMP_W       = 8;
    localparam int PIX_MAX      = 255;
    localparam int LANES        = 3;
    localparam int ACTION_W     = 2;

    localparam int BW_FIELD_W   = 7;
    localparam int BH_FIELD_W   = 7;
    localparam int COLS_FIELD_W = 10;
    localparam int ROWS_FIELD_W = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;

    localparam int ROW_LIMIT    = 1024;
    localparam int ROWS_W       = $clog2(ROW_LIMIT + 1);
    localparam int ROW_IDX_W    = $clog2(ROW_LIMIT);

    typedef logic [COMP_W-1:0] comp_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLOCK_WIDTH,
        REG_BLOCK_HEIGHT,
        REG_BLOCK_COLS,
        REG_BLOCK_ROWS
    } cfg_reg_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAME  = ACTION_W'(0),
        ACT_SET   = ACTION_W'(1),
        ACT_RESET = ACTION_W'(2)
    } action_t;

    typedef struct packed {
        logic row_start;
        logic last_col;
        logic last_row;
    } job_flags_t;

endpackage

### hw/rtl/bxavg_if.sv
`timescale 1ns / 1ps

interface bxavg_pix_if;
    import bxavg_pkg::*;

    logic  valid;
    logic  ready;
    comp_t pixel_red;
    comp_t pixel_green;
    comp_t pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                  output ready);
endinterface

interface bxavg_res_if;
    import bxavg_pkg::*;

    logic                valid;
    logic                ready;
    comp_t               avg_red;
    comp_t               avg_green;
    comp_t               avg_blue;
    logic [ACTION_W-1:0] colour_action;
    logic                row_end;
    logic                row_end_reset;
    logic                frame_end;

    modport source (output valid, output avg_red, output avg_green, output avg_blue,
                    output colour_action, output row_end, output row_end_reset,
                    output frame_end, input ready);
    modport sink (input valid, input avg_red, input avg_green, input avg_blue,
                  input colour_action, input row_end, input row_end_reset,
                  input frame_end, output ready);
endinterface

interface bxavg_cfg_if;
    import bxavg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/bxavg_ram.sv
`timescale 1ns / 1ps

module bxavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bxavg_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bxavg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNTW'(1);
                2'b01:   count_reg <= count_reg - CNTW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BXAVG_ASSERT(a_no_push_full, push |-> count_reg != CNTW'(DEPTH), "push into full queue")
    `BXAVG_ASSERT(a_no_pop_empty, pop |-> count_reg != '0, "pop from empty queue")

endmodule

### hw/rtl/bxavg_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bxavg_front #(
    parameter int MAX_BLOCK_COLS = 512,
    parameter int MAX_BLOCK_W    = 64,
    parameter int MAX_BLOCK_H    = 64
) (
    input  logic clk,
    input  logic rst_n,
    bxavg_pix_if.sink pix,
    bxavg_cfg_if.sink cfg,
    output logic ram_we,
    output logic [((MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1)-1:0] ram_waddr,
    output logic [3*$clog2(MAX_BLOCK_W*MAX_BLOCK_H*bxavg_pkg::PIX_MAX + 1)-1:0] ram_wdata,
    output logic ram_re,
    output logic [((MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1)-1:0] ram_raddr,
    input  logic [3*$clog2(MAX_BLOCK_W*MAX_BLOCK_H*bxavg_pkg::PIX_MAX + 1)-1:0] ram_rdata,
    output logic q_push,
    output logic [3*$clog2(MAX_BLOCK_W*MAX_BLOCK_H*bxavg_pkg::PIX_MAX + 1)
                  + $clog2(MAX_BLOCK_W*MAX_BLOCK_H + 1)
                  + $bits(bxavg_pkg::job_flags_t)-1:0] q_data,
    input  logic q_full
);

    import bxavg_pkg::*;

    localparam int WW    = $clog2(MAX_BLOCK_W + 1);
    localparam int HW    = $clog2(MAX_BLOCK_H + 1);
    localparam int NW    = $clog2(MAX_BLOCK_COLS + 1);
    localparam int XW    = (MAX_BLOCK_W > 1) ? $clog2(MAX_BLOCK_W) : 1;
    localparam int YW    = (MAX_BLOCK_H > 1) ? $clog2(MAX_BLOCK_H) : 1;
    localparam int CW    = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
    localparam int SUMW  = $clog2(MAX_BLOCK_W * MAX_BLOCK_H * PIX_MAX + 1);
    localparam int DIVW  = $clog2(MAX_BLOCK_W * MAX_BLOCK_H + 1);

    typedef enum logic [1:0] {
        S_ACCEPT,
        S_MERGE,
        S_PUSH
    } state_t;

    state_t              state_reg;
    logic [WW-1:0]       bw_reg;
    logic [HW-1:0]       bh_reg;
    logic [NW-1:0]       cols_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic [XW-1:0]       x_reg;
    logic [YW-1:0]       y_reg;
    logic [CW-1:0]       col_reg;
    logic [ROW_IDX_W-1:0] row_reg;
    logic                first_reg;
    logic                done_reg;

    comp_t               px_reg [LANES];
    logic [CW-1:0]       addr_reg;
    logic [LANES*SUMW-1:0] job_sum_reg;
    logic [DIVW-1:0]     job_div_reg;
    job_flags_t          job_flags_reg;

    logic [WW-1:0]       bw_clamped;
    logic [HW-1:0]       bh_clamped;
    logic [NW-1:0]       cols_clamped;
    logic [ROWS_W-1:0]   rows_clamped;
    logic                last_x;
    logic                last_y;
    logic                last_col;
    logic                last_row;
    logic                pix_xfer;
    logic [SUMW-1:0]     sum_lane [LANES];
    logic [LANES*SUMW-1:0] sum_packed;

    always_comb
    begin
        bw_clamped = WW'(MAX_BLOCK_W);
        if (cfg.data[BW_FIELD_W-1:0] == '0)
            bw_clamped = WW'(1);
        else if (32'(cfg.data[BW_FIELD_W-1:0]) <= 32'(MAX_BLOCK_W))
            bw_clamped = WW'(cfg.data[BW_FIELD_W-1:0]);

        bh_clamped = HW'(MAX_BLOCK_H);
        if (cfg.data[BH_FIELD_W-1:0] == '0)
            bh_clamped = HW'(1);
        else if (32'(cfg.data[BH_FIELD_W-1:0]) <= 32'(MAX_BLOCK_H))
            bh_clamped = HW'(cfg.data[BH_FIELD_W-1:0]);

        cols_clamped = NW'(MAX_BLOCK_COLS);
        if (cfg.data[COLS_FIELD_W-1:0] == '0)
            cols_clamped = NW'(1);
        else if (32'(cfg.data[COLS_FIELD_W-1:0]) <= 32'(MAX_BLOCK_COLS))
            cols_clamped = NW'(cfg.data[COLS_FIELD_W-1:0]);

        rows_clamped = ROWS_W'(ROW_LIMIT);
        if (cfg.data[ROWS_FIELD_W-1:0] == '0)
            rows_clamped = ROWS_W'(1);
        else if (32'(cfg.data[ROWS_FIELD_W-1:0]) <= 32'(ROW_LIMIT))
            rows_clamped = ROWS_W'(cfg.data[ROWS_FIELD_W-1:0]);
    end

    assign last_x   = (32'(x_reg) + 32'd1) >= 32'(bw_reg);
    assign last_y   = (32'(y_reg) + 32'd1) >= 32'(bh_reg);
    assign last_col = (32'(col_reg) + 32'd1) >= 32'(cols_reg);
    assign last_row = (32'(row_reg) + 32'd1) >= 32'(rows_reg);

    assign cfg.ready = 1'b1;
    assign pix.ready = (state_reg == S_ACCEPT);
    assign pix_xfer  = pix.valid && pix.ready;

    assign ram_re    = pix_xfer;
    assign ram_raddr = col_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sum_lane[k] = first_reg ? SUMW'(px_reg[k])
                                    : ram_rdata[k*SUMW +: SUMW] + SUMW'(px_reg[k]);
            sum_packed[k*SUMW +: SUMW] = sum_lane[k];
        end
    end

    assign ram_we    = (state_reg == S_MERGE);
    assign ram_waddr = addr_reg;
    assign ram_wdata = sum_packed;

    assign q_push = (state_reg == S_PUSH) && !q_full;
    assign q_data = {job_sum_reg, job_div_reg, job_flags_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCEPT;
            bw_reg    <= WW'(1);
            bh_reg    <= HW'(1);
            cols_reg  <= NW'(1);
            rows_reg  <= ROWS_W'(1);
            x_reg     <= '0;
            y_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_BLOCK_WIDTH:  bw_reg   <= bw_clamped;
                    REG_BLOCK_HEIGHT: bh_reg   <= bh_clamped;
                    REG_BLOCK_COLS:   cols_reg <= cols_clamped;
                    REG_BLOCK_ROWS:   rows_reg <= rows_clamped;
                endcase
            end

            unique case (state_reg)
                S_ACCEPT:
                begin
                    if (pix_xfer)
                    begin
                        first_reg <= (x_reg == '0) && (y_reg == '0);
                        done_reg  <= last_x && last_y;
                        state_reg <= S_MERGE;
                        if (!last_x)
                        begin
                            x_reg <= x_reg + XW'(1);
                        end
                        else
                        begin
                            x_reg <= '0;
                            if (!last_col)
                            begin
                                col_reg <= col_reg + CW'(1);
                            end
                            else
                            begin
                                col_reg <= '0;
                                if (!last_y)
                                begin
                                    y_reg <= y_reg + YW'(1);
                                end
                                else
                                begin
                                    y_reg <= '0;
                                    row_reg <= last_row ? '0 : row_reg + ROW_IDX_W'(1);
                                end
                            end
                        end
                    end
                end
                S_MERGE:
                begin
                    state_reg <= done_reg ? S_PUSH : S_ACCEPT;
                end
                S_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= S_ACCEPT;
                    end
                end
                default:
                begin
                    state_reg <= S_ACCEPT;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            px_reg[0]     <= pix.pixel_red;
            px_reg[1]     <= pix.pixel_green;
            px_reg[2]     <= pix.pixel_blue;
            addr_reg      <= col_reg;
            job_div_reg   <= DIVW'(32'(bw_reg) * 32'(bh_reg));
            job_flags_reg <= '{row_start: (col_reg == '0), last_col: last_col,
                               last_row: last_row};
        end
        if (state_reg == S_MERGE)
        begin
            job_sum_reg <= sum_packed;
        end
    end

    `BXAVG_ASSERT_NEXT(a_xfer_merges, pix_xfer, ram_we, "accepted pixel not merged")
    `BXAVG_ASSERT(a_push_after_done, q_push |-> done_reg, "job pushed for unfinished block")

endmodule

### hw/rtl/bxavg_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bxavg_back #(
    parameter int MAX_BLOCK_W = 64,
    parameter int MAX_BLOCK_H = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  logic [3*$clog2(MAX_BLOCK_W*MAX_BLOCK_H*bxavg_pkg::PIX_MAX + 1)
                  + $clog2(MAX_BLOCK_W*MAX_BLOCK_H + 1)
                  + $bits(bxavg_pkg::job_flags_t)-1:0] q_data,
    output logic q_pop,
    bxavg_res_if.source res
);

    import bxavg_pkg::*;

    localparam int SUMW  = $clog2(MAX_BLOCK_W * MAX_BLOCK_H * PIX_MAX + 1);
    localparam int DIVW  = $clog2(MAX_BLOCK_W * MAX_BLOCK_H + 1);
    localparam int FLW   = $bits(job_flags_t);
    localparam int JOB_W = LANES * SUMW + DIVW + FLW;
    localparam int SW    = $clog2(SUMW);
    localparam int CLRW  = LANES * COMP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [SW-1:0]    step_reg;
    logic             out_valid_reg;
    logic [CLRW-1:0]  last_colour_reg;

    logic [DIVW-1:0]  div_reg;
    job_flags_t       flags_reg;
    logic [DIVW-1:0]  rem_reg [LANES];
    logic [SUMW-1:0]  dq_reg [LANES];
    comp_t            avg_reg [LANES];
    action_t          action_reg;
    logic             row_end_reg;
    logic             row_end_reset_reg;
    logic             frame_end_reg;

    logic [LANES*SUMW-1:0] q_sums;
    logic [DIVW:0]    trial [LANES];
    logic             ge [LANES];
    logic [DIVW-1:0]  rem_step [LANES];
    logic [SUMW-1:0]  dq_step [LANES];
    logic             out_free;
    logic             emit;
    logic [CLRW-1:0]  colour;
    logic [CLRW-1:0]  base_colour;
    logic [CLRW-1:0]  colour_next;
    action_t          action;

    assign q_sums   = q_data[JOB_W-1 -: LANES*SUMW];
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || res.ready;
    assign emit     = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            trial[k]    = {rem_reg[k], dq_reg[k][SUMW-1]};
            ge[k]       = trial[k] >= {1'b0, div_reg};
            rem_step[k] = ge[k] ? DIVW'(trial[k] - {1'b0, div_reg}) : trial[k][DIVW-1:0];
            dq_step[k]  = {dq_reg[k][SUMW-2:0], ge[k]};
        end
    end

    always_comb
    begin
        colour      = {dq_reg[0][COMP_W-1:0], dq_reg[1][COMP_W-1:0], dq_reg[2][COMP_W-1:0]};
        base_colour = flags_reg.row_start ? '0 : last_colour_reg;
        action      = ACT_SAME;
        colour_next = base_colour;
        if (colour != base_colour)
        begin
            action      = (colour == '0) ? ACT_RESET : ACT_SET;
            colour_next = colour;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
            last_colour_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg   <= 1'b1;
                last_colour_reg <= colour_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (q_pop)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(SUMW - 1))
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            div_reg   <= q_data[FLW +: DIVW];
            flags_reg <= job_flags_t'(q_data[FLW-1:0]);
            for (int k = 0; k < LANES; k++)
            begin
                rem_reg[k] <= '0;
                dq_reg[k]  <= q_sums[k*SUMW +: SUMW];
            end
        end
        else if (state_reg == S_DIV)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                rem_reg[k] <= rem_step[k];
                dq_reg[k]  <= dq_step[k];
            end
        end

        if (emit)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                avg_reg[k] <= dq_reg[k][COMP_W-1:0];
            end
            action_reg        <= action;
            row_end_reg       <= flags_reg.last_col;
            row_end_reset_reg <= flags_reg.last_col && (colour_next != '0);
            frame_end_reg     <= flags_reg.last_col && flags_reg.last_row;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.avg_red       = avg_reg[0];
    assign res.avg_green     = avg_reg[1];
    assign res.avg_blue      = avg_reg[2];
    assign res.colour_action = action_reg;
    assign res.row_end       = row_end_reg;
    assign res.row_end_reset = row_end_reset_reg;
    assign res.frame_end     = frame_end_reg;

    `BXAVG_ASSERT(a_div_nonzero, state_reg == S_DIV |-> div_reg != '0, "zero divisor in divider")
    `BXAVG_ASSERT(a_row_closed_black, res.valid && res.row_end && !res.row_end_reset |->
        last_colour_reg == '0, "row closed without reset on non-black colour")

endmodule

### hw/rtl/box_average_downsample.sv
// Box-average downsampler: RGB pixels enter in row-major order, each block of
// block_width by block_height pixels is summed per block column in a single-port-read
// accumulator RAM, and every finished block yields its truncated mean colour together
// with a background-colour action and row and frame end flags. A pixel is accepted
// with a RAM read, then merged and written back, and one that closes a block also
// waits in a push state while the job queue is full; a finished block then holds the
// back end for load, divide (one quotient bit per cycle over the 20-bit sum with the
// default parameters, in three parallel divider lanes) and emit, so small blocks are
// paced by the divider while a two-entry job queue lets pixel intake run ahead.
// Accumulator entries are overwritten by the first pixel of each block, so there is
// no clearing pass after reset. Write configuration only while the block is idle.
`timescale 1ns / 1ps

module box_average_downsample #(
    parameter int MAX_BLOCK_COLS = 512,
    parameter int MAX_BLOCK_W    = 64,
    parameter int MAX_BLOCK_H    = 64
) (
    input  logic clk,
    input  logic rst_n,
    bxavg_cfg_if.sink   cfg,
    bxavg_pix_if.sink   pix,
    bxavg_res_if.source res
);

    import bxavg_pkg::*;

    localparam int CW    = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
    localparam int SUMW  = $clog2(MAX_BLOCK_W * MAX_BLOCK_H * PIX_MAX + 1);
    localparam int DIVW  = $clog2(MAX_BLOCK_W * MAX_BLOCK_H + 1);
    localparam int JOB_W = LANES * SUMW + DIVW + $bits(job_flags_t);
    localparam int QUEUE_DEPTH = 2;

    logic                  ram_we;
    logic [CW-1:0]         ram_waddr;
    logic [LANES*SUMW-1:0] ram_wdata;
    logic                  ram_re;
    logic [CW-1:0]         ram_raddr;
    logic [LANES*SUMW-1:0] ram_rdata;

    logic                  q_push;
    logic [JOB_W-1:0]      q_push_data;
    logic                  q_full;
    logic                  q_pop;
    logic [JOB_W-1:0]      q_pop_data;
    logic                  q_empty;

    bxavg_ram #(
        .WIDTH (LANES * SUMW),
        .DEPTH (MAX_BLOCK_COLS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bxavg_front #(
        .MAX_BLOCK_COLS (MAX_BLOCK_COLS),
        .MAX_BLOCK_W    (MAX_BLOCK_W),
        .MAX_BLOCK_H    (MAX_BLOCK_H)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .q_push    (q_push),
        .q_data    (q_push_data),
        .q_full    (q_full)
    );

    bxavg_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    bxavg_back #(
        .MAX_BLOCK_W (MAX_BLOCK_W),
        .MAX_BLOCK_H (MAX_BLOCK_H)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule
